@@ src/met_pkg.sv @@
// package for the escape-time block: register indexes, fixed field widths,
// controller states and the command and status bundles between controller and datapath
// no dependencies
package met_pkg;

    localparam int COORD_W     = 32;
    localparam int PIX_W       = 12;
    localparam int DIM_W       = 13;
    localparam int COUNT_W     = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [COORD_W-1:0] REAL_MIN_RST = -32'sd671088640;
    localparam logic signed [COORD_W-1:0] REAL_MAX_RST = 32'sd268435456;
    localparam logic signed [COORD_W-1:0] IMAG_MIN_RST = -32'sd268435456;
    localparam logic signed [COORD_W-1:0] IMAG_MAX_RST = 32'sd268435456;
    localparam logic [DIM_W-1:0]          WIDTH_RST    = 13'd640;
    localparam logic [DIM_W-1:0]          HEIGHT_RST   = 13'd480;
    localparam logic [COUNT_W-1:0]        LIMIT_RST    = 16'd1000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REAL_MIN   = 3'd0,
        REG_REAL_MAX   = 3'd1,
        REG_IMAG_MIN   = 3'd2,
        REG_IMAG_MAX   = 3'd3,
        REG_WIDTH      = 3'd4,
        REG_HEIGHT     = 3'd5,
        REG_ITER_LIMIT = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_MAP,
        ST_ITER_MUL,
        ST_ITER_ADD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic scale;
        logic div_start;
        logic map;
        logic mul;
        logic update;
        logic load_out;
    } met_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic at_limit;
        logic in_range;
        logic escaped;
        logic out_free;
    } met_status_t;

endpackage

@@ src/met_divider.sv @@
// iterative restoring divider, one quotient bit per cycle, truncating toward zero
// returns magnitude of the quotient and the sign of the dividend
// depends on nothing but its parameters
module met_divider #(
    parameter int NUMW = 44,
    parameter int DVW  = 13
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [NUMW:0]   dividend,
    input  logic [DVW-1:0]         divisor,
    output logic                   busy,
    output logic [NUMW-1:0]        quotient,
    output logic                   negative
);

    localparam int CNTW = $clog2(NUMW + 1);

    logic [CNTW-1:0]   cnt_reg;
    logic [NUMW-1:0]   quo_reg;
    logic [DVW-1:0]    rem_reg;
    logic [DVW-1:0]    rem_next;
    logic              neg_reg;
    logic [NUMW-1:0]   mag;
    logic [DVW:0]      rem_sh;
    logic              q_bit;
    logic signed [NUMW:0] neg_dividend;

    assign neg_dividend = -dividend;
    assign mag          = dividend[NUMW] ? neg_dividend[NUMW-1:0] : dividend[NUMW-1:0];
    assign rem_sh       = {rem_reg, quo_reg[NUMW-1]};
    assign q_bit        = rem_sh >= {1'b0, divisor};
    assign rem_next     = q_bit ? DVW'(rem_sh - {1'b0, divisor}) : rem_sh[DVW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNTW'(NUMW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= mag;
            rem_reg <= '0;
            neg_reg <= dividend[NUMW];
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[NUMW-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;
    assign negative = neg_reg;

endmodule

@@ src/met_controller.sv @@
// sequencing state machine: input capture, pixel mapping, iteration loop, result hand-off
// depends on met_pkg
module met_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 in_ready,
    input  met_pkg::met_status_t st,
    output met_pkg::met_cmd_t    cmd
);

    met_pkg::state_t state_reg;
    met_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= met_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            met_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = met_pkg::ST_SCALE;
            end
            met_pkg::ST_SCALE:    state_next = met_pkg::ST_DIV_LOAD;
            met_pkg::ST_DIV_LOAD: state_next = met_pkg::ST_DIV_WAIT;
            met_pkg::ST_DIV_WAIT: begin
                if (!st.div_busy) state_next = met_pkg::ST_MAP;
            end
            met_pkg::ST_MAP:      state_next = met_pkg::ST_ITER_MUL;
            met_pkg::ST_ITER_MUL: begin
                if (st.at_limit || !st.in_range) begin
                    state_next = met_pkg::ST_FINISH;
                end else begin
                    state_next = met_pkg::ST_ITER_ADD;
                end
            end
            met_pkg::ST_ITER_ADD: begin
                if (st.escaped) begin
                    state_next = met_pkg::ST_FINISH;
                end else begin
                    state_next = met_pkg::ST_ITER_MUL;
                end
            end
            met_pkg::ST_FINISH: begin
                if (st.out_free) state_next = met_pkg::ST_IDLE;
            end
            default: state_next = met_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            met_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            met_pkg::ST_SCALE:    cmd.scale     = 1'b1;
            met_pkg::ST_DIV_LOAD: cmd.div_start = 1'b1;
            met_pkg::ST_DIV_WAIT: cmd           = '0;
            met_pkg::ST_MAP:      cmd.map       = 1'b1;
            met_pkg::ST_ITER_MUL: cmd.mul       = 1'b1;
            met_pkg::ST_ITER_ADD: cmd.update    = !st.escaped;
            met_pkg::ST_FINISH:   cmd.load_out  = st.out_free;
            default:              cmd           = '0;
        endcase
    end

endmodule

@@ src/met_datapath.sv @@
// datapath: configuration registers, pixel-to-plane mapping, complex squaring loop
// and the result register; depends on met_pkg and met_divider
module met_datapath #(
    parameter int FRAC_BITS = 28,
    parameter int MAX_DIM   = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [met_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [met_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [2*met_pkg::PIX_W-1:0]         in_data,
    input  met_pkg::met_cmd_t                   cmd,
    output met_pkg::met_status_t                st,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [met_pkg::COUNT_W-1:0]         out_count
);

    localparam int DVW  = $clog2(MAX_DIM + 1);
    localparam int SPW  = met_pkg::COORD_W + 1;
    localparam int NUMW = met_pkg::COORD_W + met_pkg::PIX_W;
    localparam int PRW  = NUMW + 1;
    localparam int CW   = PRW + 1;
    localparam int ZW   = ((CW > FRAC_BITS + 4) ? CW : FRAC_BITS + 4) + 1;
    localparam int MW   = FRAC_BITS + 3;
    localparam int SQW  = FRAC_BITS + 4;
    localparam int SUMW = SQW + 1;
    localparam int CW_I = met_pkg::COUNT_W;

    localparam logic signed [ZW-1:0] TWO_C =
        {{(ZW-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
    localparam logic signed [ZW-1:0] NEG_TWO_C = -TWO_C;
    localparam logic signed [SUMW-1:0] FOUR_C =
        {2'b00, 3'b100, {FRAC_BITS{1'b0}}};

    // configuration
    logic signed [met_pkg::COORD_W-1:0] real_min_reg, real_max_reg;
    logic signed [met_pkg::COORD_W-1:0] imag_min_reg, imag_max_reg;
    logic [met_pkg::DIM_W-1:0]          width_reg, height_reg;
    logic [CW_I-1:0]                    limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_min_reg <= met_pkg::REAL_MIN_RST;
            real_max_reg <= met_pkg::REAL_MAX_RST;
            imag_min_reg <= met_pkg::IMAG_MIN_RST;
            imag_max_reg <= met_pkg::IMAG_MAX_RST;
            width_reg    <= met_pkg::WIDTH_RST;
            height_reg   <= met_pkg::HEIGHT_RST;
            limit_reg    <= met_pkg::LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                met_pkg::REG_REAL_MIN:   real_min_reg <= $signed(cfg_wdata);
                met_pkg::REG_REAL_MAX:   real_max_reg <= $signed(cfg_wdata);
                met_pkg::REG_IMAG_MIN:   imag_min_reg <= $signed(cfg_wdata);
                met_pkg::REG_IMAG_MAX:   imag_max_reg <= $signed(cfg_wdata);
                met_pkg::REG_WIDTH:      width_reg    <= cfg_wdata[met_pkg::DIM_W-1:0];
                met_pkg::REG_HEIGHT:     height_reg   <= cfg_wdata[met_pkg::DIM_W-1:0];
                met_pkg::REG_ITER_LIMIT: limit_reg    <= cfg_wdata[CW_I-1:0];
                default: ;
            endcase
        end
    end

    // effective divisors: zero reads as one, oversize clamps
    logic [DVW-1:0] width_eff, height_eff;

    always_comb begin
        if (width_reg == '0) begin
            width_eff = DVW'(1);
        end else if (32'(width_reg) > 32'(MAX_DIM)) begin
            width_eff = DVW'(MAX_DIM);
        end else begin
            width_eff = DVW'(width_reg);
        end
        if (height_reg == '0) begin
            height_eff = DVW'(1);
        end else if (32'(height_reg) > 32'(MAX_DIM)) begin
            height_eff = DVW'(MAX_DIM);
        end else begin
            height_eff = DVW'(height_reg);
        end
    end

    // pixel capture and scaling
    logic [met_pkg::PIX_W-1:0] col_reg, row_reg;
    logic signed [SPW-1:0]     span_re, span_im;
    logic signed [PRW-1:0]     prod_re, prod_im;
    logic signed [PRW-1:0]     prod_re_reg, prod_im_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            col_reg <= in_data[met_pkg::PIX_W-1:0];
            row_reg <= in_data[2*met_pkg::PIX_W-1:met_pkg::PIX_W];
        end
        if (cmd.scale) begin
            prod_re_reg <= prod_re;
            prod_im_reg <= prod_im;
        end
    end

    assign span_re = SPW'(real_max_reg) - SPW'(real_min_reg);
    assign span_im = SPW'(imag_max_reg) - SPW'(imag_min_reg);
    assign prod_re = PRW'(span_re) * PRW'($signed({1'b0, col_reg}));
    assign prod_im = PRW'(span_im) * PRW'($signed({1'b0, row_reg}));

    logic            re_busy, im_busy, re_neg, im_neg;
    logic [NUMW-1:0] re_quo, im_quo;

    met_divider #(.NUMW(NUMW), .DVW(DVW)) u_div_re (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_re_reg),
        .divisor  (width_eff),
        .busy     (re_busy),
        .quotient (re_quo),
        .negative (re_neg)
    );

    met_divider #(.NUMW(NUMW), .DVW(DVW)) u_div_im (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_im_reg),
        .divisor  (height_eff),
        .busy     (im_busy),
        .quotient (im_quo),
        .negative (im_neg)
    );

    // plane point
    logic signed [CW-1:0] re_q, im_q, cr_next, ci_next;
    logic signed [CW-1:0] cr_reg, ci_reg;

    assign re_q    = $signed({2'b00, re_quo});
    assign im_q    = $signed({2'b00, im_quo});
    assign cr_next = re_neg ? CW'(real_min_reg) - re_q : CW'(real_min_reg) + re_q;
    assign ci_next = im_neg ? CW'(imag_min_reg) - im_q : CW'(imag_min_reg) + im_q;

    // iteration
    logic signed [ZW-1:0]     x_reg, y_reg, x_next, y_next;
    logic [CW_I-1:0]          count_reg;
    logic signed [MW-1:0]     x_op, y_op;
    logic signed [2*MW-1:0]   xx_full, yy_full, xy_full;
    logic signed [SQW-1:0]    xx_reg, yy_reg, xy_reg;
    logic signed [SUMW-1:0]   mag_sq;

    assign x_op    = $signed(x_reg[MW-1:0]);
    assign y_op    = $signed(y_reg[MW-1:0]);
    assign xx_full = x_op * x_op;
    assign yy_full = y_op * y_op;
    assign xy_full = x_op * y_op;

    assign mag_sq  = SUMW'(xx_reg) + SUMW'(yy_reg);
    assign x_next  = ZW'(xx_reg) - ZW'(yy_reg) + ZW'(cr_reg);
    assign y_next  = (ZW'(xy_reg) <<< 1) + ZW'(ci_reg);

    always_ff @(posedge aclk) begin
        if (cmd.map) begin
            cr_reg    <= cr_next;
            ci_reg    <= ci_next;
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
        end else if (cmd.update) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.mul) begin
            xx_reg <= xx_full[FRAC_BITS +: SQW];
            yy_reg <= yy_full[FRAC_BITS +: SQW];
            xy_reg <= xy_full[FRAC_BITS +: SQW];
        end
    end

    // result register
    logic            out_valid_reg;
    logic [CW_I-1:0] out_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) out_count_reg <= count_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

    assign st.div_busy = re_busy || im_busy;
    assign st.at_limit = count_reg >= limit_reg;
    assign st.in_range = (x_reg <= TWO_C) && (x_reg >= NEG_TWO_C) &&
                         (y_reg <= TWO_C) && (y_reg >= NEG_TWO_C);
    assign st.escaped  = mag_sq > FOUR_C;
    assign st.out_free = !out_valid_reg || out_ready;

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_div_not_restarted: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (!re_busy && !im_busy))
        else $error("divider restarted while busy");

    a_update_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (count_reg < limit_reg))
        else $error("iteration past the limit");

    a_update_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> $past(cmd.mul))
        else $error("update without fresh products");

endmodule

@@ src/mandelbrot_escape_time.sv @@
// top level of the escape-time block: controller plus datapath
// depends on met_pkg, met_controller, met_datapath, met_divider
//
// usage:
//   one slave-side transaction carries one pixel (column, row); one master-side
//   transaction returns its escape count. configuration is written through
//   cfg_wr_en / cfg_addr / cfg_wdata while the block is idle; reset loads the
//   default view (-2.5..1.0, -1.0..1.0, 640x480, limit 1000) and leaves no
//   result pending.
//   one pixel at a time: s_tready is high only between pixels. from acceptance
//   to result a pixel passes the bit-serial coordinate dividers, then the
//   squaring loop (multiply, then add and test) until it escapes or reaches
//   the limit; its escape count is at most the limit.
//   the result sits in an output register; the next pixel is accepted while it
//   waits. if the receiver stalls, a second finished result holds in the loop
//   until the output register frees.
module mandelbrot_escape_time #(
    parameter int FRAC_BITS = 28,
    parameter int MAX_DIM   = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [met_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [met_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*met_pkg::PIX_W-1:0]         s_tdata,  // pixel_column, pixel_row
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [met_pkg::COUNT_W-1:0]         m_tdata   // escape_count
);

    met_pkg::met_cmd_t    cmd;
    met_pkg::met_status_t st;

    met_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    met_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_DIM(MAX_DIM)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_count (m_tdata)
    );

endmodule

@@ test/tb_mandelbrot_escape_time.sv @@
`timescale 1ns / 1ps
// testbench for mandelbrot_escape_time: directed and random pixels under many views,
// each escape count checked against a fixed-point predictor of the iteration
// depends on met_pkg and mandelbrot_escape_time
module tb_mandelbrot_escape_time;

    localparam int FRAC_BITS = 28;
    localparam int MAX_DIM   = 4096;
    localparam int signed Q_ONE = 1 << FRAC_BITS;
    localparam logic [met_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam longint TIMEOUT_NS = 64'd100_000_000;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_wr_en;
    logic [met_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [met_pkg::CFG_DATA_W-1:0]     cfg_wdata;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [2*met_pkg::PIX_W-1:0]        s_tdata;   // pixel_column, pixel_row
    logic                               m_tvalid;
    logic                               m_tready;
    logic [met_pkg::COUNT_W-1:0]        m_tdata;   // escape_count

    logic signed [met_pkg::COORD_W-1:0] view_real_min;
    logic signed [met_pkg::COORD_W-1:0] view_real_max;
    logic signed [met_pkg::COORD_W-1:0] view_imag_min;
    logic signed [met_pkg::COORD_W-1:0] view_imag_max;
    logic [met_pkg::DIM_W-1:0]          view_width;
    logic [met_pkg::DIM_W-1:0]          view_height;
    logic [met_pkg::COUNT_W-1:0]        view_limit;

    logic [met_pkg::COUNT_W-1:0] expected_counts[$];
    int error_count  = 0;
    int hold_request = 0;
    bit idle_en      = 1'b1;

    mandelbrot_escape_time #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // floor(a*b / 2^FRAC_BITS)
    function automatic longint mul_q(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        wa   = a;
        wb   = b;
        prod = (wa * wb) >>> FRAC_BITS;
        return prod[63:0];
    endfunction

    function automatic longint map_coord(input longint lo, input longint hi,
                                         input longint pix, input longint dim);
        longint span;
        longint dim_used;
        span     = hi - lo;
        dim_used = (dim == 0) ? 1 : ((dim > MAX_DIM) ? MAX_DIM : dim);
        return lo + (span * pix) / dim_used;
    endfunction

    function automatic logic [met_pkg::COUNT_W-1:0] predict_escape(
        input logic [met_pkg::PIX_W-1:0] col,
        input logic [met_pkg::PIX_W-1:0] row);
        longint cr, ci, x, y, xx, yy, xn, two, four;
        int unsigned n;
        bit escaped;
        cr = map_coord(longint'(view_real_min), longint'(view_real_max),
                       longint'(col), longint'(view_width));
        ci = map_coord(longint'(view_imag_min), longint'(view_imag_max),
                       longint'(row), longint'(view_height));
        two     = longint'(2) << FRAC_BITS;
        four    = longint'(4) << FRAC_BITS;
        x       = 0;
        y       = 0;
        n       = 0;
        escaped = 1'b0;
        while (!escaped && n < view_limit) begin
            // a large component escapes without forming the squares
            if (x > two || x < -two || y > two || y < -two) begin
                escaped = 1'b1;
            end else begin
                xx = mul_q(x, x);
                yy = mul_q(y, y);
                if (xx + yy > four) begin
                    escaped = 1'b1;
                end else begin
                    xn = xx - yy + cr;
                    y  = 2 * mul_q(x, y) + ci;
                    x  = xn;
                    n++;
                end
            end
        end
        return n[met_pkg::COUNT_W-1:0];
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                flag_error($sformatf("unexpected result transaction: escape_count %0d", m_tdata));
            end else if (m_tdata !== expected_counts[0]) begin
                flag_error($sformatf("escape_count mismatch: expected %0d, actual %0d",
                                     expected_counts[0], m_tdata));
                void'(expected_counts.pop_front());
            end else begin
                void'(expected_counts.pop_front());
            end
        end
    end

    // result side: random stalls, long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                m_tready = 1'b0;
                hold_request--;
            end else begin
                m_tready = !idle_en || ($urandom_range(99) >= 31);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic wait_drained();
        while (expected_counts.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [met_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [met_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (addr)
            met_pkg::REG_REAL_MIN:   view_real_min = value;
            met_pkg::REG_REAL_MAX:   view_real_max = value;
            met_pkg::REG_IMAG_MIN:   view_imag_min = value;
            met_pkg::REG_IMAG_MAX:   view_imag_max = value;
            met_pkg::REG_WIDTH:      view_width    = value[met_pkg::DIM_W-1:0];
            met_pkg::REG_HEIGHT:     view_height   = value[met_pkg::DIM_W-1:0];
            met_pkg::REG_ITER_LIMIT: view_limit    = value[met_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [met_pkg::COORD_W-1:0] rmin,
                              input logic [met_pkg::COORD_W-1:0] rmax,
                              input logic [met_pkg::COORD_W-1:0] imin,
                              input logic [met_pkg::COORD_W-1:0] imax,
                              input logic [met_pkg::DIM_W-1:0] w,
                              input logic [met_pkg::DIM_W-1:0] h,
                              input logic [met_pkg::COUNT_W-1:0] lim);
        wait_drained();
        write_reg(met_pkg::REG_REAL_MIN, rmin);
        write_reg(met_pkg::REG_REAL_MAX, rmax);
        write_reg(met_pkg::REG_IMAG_MIN, imin);
        write_reg(met_pkg::REG_IMAG_MAX, imax);
        write_reg(met_pkg::REG_WIDTH, met_pkg::CFG_DATA_W'(w));
        write_reg(met_pkg::REG_HEIGHT, met_pkg::CFG_DATA_W'(h));
        write_reg(met_pkg::REG_ITER_LIMIT, met_pkg::CFG_DATA_W'(lim));
    endtask

    task automatic send_pixel(input logic [met_pkg::PIX_W-1:0] col,
                              input logic [met_pkg::PIX_W-1:0] row);
        while (idle_en && $urandom_range(99) < 31) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_counts.push_back(predict_escape(col, row));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd457, 12'd240);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd320, 12'd0);
    endtask

    task automatic test_dimension_clamping();
        // zero size acts as one
        load_setup(-5 * Q_ONE / 2, Q_ONE, -Q_ONE, Q_ONE, 13'd0, 13'd0, 16'd64);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        // sizes above the maximum are clamped
        load_setup(-5 * Q_ONE / 2, Q_ONE, -Q_ONE, Q_ONE, 13'd8191, 13'd4097, 16'd64);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1024);
        load_setup(-5 * Q_ONE / 2, Q_ONE, -Q_ONE, Q_ONE, 13'd4096, 13'd4096, 16'd64);
        send_pixel(12'd3000, 12'd2048);
    endtask

    task automatic test_iteration_limits();
        load_setup(0, 0, 0, 0, 13'd640, 13'd480, 16'd0);
        send_pixel(12'd100, 12'd100);
        load_setup(0, 0, 0, 0, 13'd640, 13'd480, 16'd1);
        send_pixel(12'd5, 12'd5);
        // c = 0 never escapes, full count
        load_setup(0, 0, 0, 0, 13'd640, 13'd480, 16'd65535);
        send_pixel(12'd0, 12'd0);
        // c = -2 sits exactly on the escape boundary
        load_setup(-2 * Q_ONE, -2 * Q_ONE, 0, 0, 13'd640, 13'd480, 16'd100);
        send_pixel(12'd10, 12'd10);
        load_setup(-5 * Q_ONE / 2, Q_ONE, -Q_ONE, Q_ONE, 13'd640, 13'd480, 16'd65535);
        send_pixel(12'd0, 12'd100);
    endtask

    task automatic test_view_extremes();
        // widest view, imaginary axis reversed
        load_setup(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   13'd4096, 13'd4096, 16'd50);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd4094);
        load_setup(Q_ONE, -2 * Q_ONE, Q_ONE / 2, -Q_ONE, 13'd7, 13'd5, 16'd40);
        send_pixel(12'd3, 12'd2);
        send_pixel(12'd6, 12'd4);
    endtask

    task automatic test_unmapped_index();
        load_setup(-5 * Q_ONE / 2, Q_ONE, -Q_ONE, Q_ONE, 13'd640, 13'd480, 16'd30);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        send_pixel(12'd200, 12'd200);
        send_pixel(12'd0, 12'd479);
    endtask

    task automatic test_output_stall();
        int i;
        load_setup(-5 * Q_ONE / 2, Q_ONE, -Q_ONE, Q_ONE, 13'd64, 13'd64, 16'd16);
        hold_request = 500;
        for (i = 0; i < 6; i++) begin
            send_pixel(met_pkg::PIX_W'($urandom_range(63)),
                       met_pkg::PIX_W'($urandom_range(63)));
        end
    endtask

    function automatic logic [met_pkg::DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return met_pkg::DIM_W'($urandom_range(4097, 8191));
        if (r <= 4) return met_pkg::DIM_W'($urandom_range(1, 4096));
        return met_pkg::DIM_W'($urandom_range(1, 64));
    endfunction

    task automatic test_random_pixels(input int phases, input int per_phase);
        int ph, i, r;
        int signed c_re, c_im, h_re, h_im, lo_re, hi_re, lo_im, hi_im, t;
        logic [met_pkg::DIM_W-1:0] w, h;
        logic [met_pkg::COUNT_W-1:0] lim;
        logic [met_pkg::PIX_W-1:0] col, row;
        for (ph = 0; ph < phases; ph++) begin
            w = pick_dim();
            h = pick_dim();
            r = $urandom_range(99);
            if (r < 3) lim = '0;
            else if (r < 85) lim = met_pkg::COUNT_W'($urandom_range(1, 32));
            else lim = met_pkg::COUNT_W'($urandom_range(33, 255));
            if ($urandom_range(3) == 0) begin
                lo_re = int'($urandom());
                hi_re = int'($urandom());
                lo_im = int'($urandom());
                hi_im = int'($urandom());
            end else begin
                c_re  = int'($urandom_range(3 * Q_ONE)) - 2 * Q_ONE;
                c_im  = int'($urandom_range(3 * Q_ONE)) - 3 * Q_ONE / 2;
                h_re  = int'($urandom_range(1, Q_ONE) >> $urandom_range(20));
                h_im  = int'($urandom_range(1, Q_ONE) >> $urandom_range(20));
                lo_re = c_re - h_re;
                hi_re = c_re + h_re;
                lo_im = c_im - h_im;
                hi_im = c_im + h_im;
                if ($urandom_range(7) == 0) begin
                    t     = lo_re;
                    lo_re = hi_re;
                    hi_re = t;
                end
                if ($urandom_range(7) == 0) begin
                    t     = lo_im;
                    lo_im = hi_im;
                    hi_im = t;
                end
            end
            load_setup(lo_re, hi_re, lo_im, hi_im, w, h, lim);
            idle_en = (ph != 2);
            for (i = 0; i < per_phase; i++) begin
                if ($urandom_range(9) < 8) begin
                    col = (w == 0) ? '0 : met_pkg::PIX_W'($urandom_range(
                              (w > MAX_DIM) ? MAX_DIM - 1 : int'(w) - 1));
                    row = (h == 0) ? '0 : met_pkg::PIX_W'($urandom_range(
                              (h > MAX_DIM) ? MAX_DIM - 1 : int'(h) - 1));
                end else begin
                    col = met_pkg::PIX_W'($urandom());
                    row = met_pkg::PIX_W'($urandom());
                end
                send_pixel(col, row);
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        view_real_min = met_pkg::REAL_MIN_RST;
        view_real_max = met_pkg::REAL_MAX_RST;
        view_imag_min = met_pkg::IMAG_MIN_RST;
        view_imag_max = met_pkg::IMAG_MAX_RST;
        view_width    = met_pkg::WIDTH_RST;
        view_height   = met_pkg::HEIGHT_RST;
        view_limit    = met_pkg::LIMIT_RST;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_dimension_clamping();
        test_iteration_limits();
        test_view_extremes();
        test_unmapped_index();
        test_output_stall();
        test_random_pixels(10, 60);

        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_counts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
